// ===== rtl/core/aalr_pkg.sv =====
// ----------------------------------------------------------------------------
// Antialiased line rasterizer package
// Shared action and pixel-select codes, widths and controller/datapath structs.
// ----------------------------------------------------------------------------
package aalr_pkg;

   localparam logic ACT_BEGIN   = 1'b0;
   localparam logic ACT_ADVANCE = 1'b1;

   localparam int SEL_W   = 3;
   localparam int COV_W   = 9;
   localparam int COLOR_W = 24;

   localparam logic [SEL_W-1:0] PIX_BEGIN_LO = 3'd0;
   localparam logic [SEL_W-1:0] PIX_BEGIN_HI = 3'd1;
   localparam logic [SEL_W-1:0] PIX_END_LO   = 3'd2;
   localparam logic [SEL_W-1:0] PIX_END_HI   = 3'd3;
   localparam logic [SEL_W-1:0] PIX_ADV_LO   = 3'd4;
   localparam logic [SEL_W-1:0] PIX_ADV_HI   = 3'd5;

   localparam logic [COV_W-1:0] COV_FULL = 9'd256;

   typedef struct packed {
      logic             latch;
      logic             setup;
      logic             div_step;
      logic             endp;
      logic             prep;
      logic [SEL_W-1:0] sel;
      logic             load;
      logic             advance;
   } cmd_type;

   typedef struct packed {
      logic action;
      logic line_active;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/aalr_control.sv =====
// ----------------------------------------------------------------------------
// Antialiased line rasterizer controller
// Sequences setup, gradient division, endpoint math and pixel transfers.
// ----------------------------------------------------------------------------
module aalr_control #(
   parameter int DIV_STEPS = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  aalr_pkg::status_type status,
   output aalr_pkg::cmd_type    cmd
);

   localparam int CNTW = $clog2(DIV_STEPS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_ENDP  = 3'd3;
   localparam logic [2:0] ST_PREP  = 3'd4;
   localparam logic [2:0] ST_LOAD  = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [aalr_pkg::SEL_W-1:0] sel_ff, sel_in;
   logic [CNTW-1:0]            cnt_ff, cnt_in;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.sel      = sel_ff;
      req_ready    = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               if (status.action == aalr_pkg::ACT_ADVANCE) begin
                  if (status.line_active) begin
                     sel_in   = aalr_pkg::PIX_ADV_LO;
                     state_in = ST_PREP;
                  end
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = CNTW'(DIV_STEPS - 1);
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_ENDP;
            end else begin
               cnt_in = cnt_ff - CNTW'(1);
            end
         end
         ST_ENDP: begin
            cmd.endp = 1'b1;
            sel_in   = aalr_pkg::PIX_BEGIN_LO;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               if (sel_ff == aalr_pkg::PIX_END_HI) begin
                  state_in = ST_IDLE;
               end else if (sel_ff == aalr_pkg::PIX_ADV_HI) begin
                  cmd.advance = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  sel_in   = sel_ff + aalr_pkg::SEL_W'(1);
                  state_in = ST_PREP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= aalr_pkg::PIX_BEGIN_LO;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/aalr_datapath.sv =====
// ----------------------------------------------------------------------------
// Antialiased line rasterizer datapath
// Axis swap, restoring gradient divider, endpoint math, coverage and shading.
// ----------------------------------------------------------------------------
module aalr_datapath #(
   parameter int COORD_INT_BITS  = 12,
   parameter int COORD_FRAC_BITS = 4,
   parameter int SLOPE_FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  aalr_pkg::cmd_type                       cmd,
   output aalr_pkg::status_type                    status,
   input  logic                                    req_action,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_x_start,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_y_start,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_x_finish,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_y_finish,
   input  logic [aalr_pkg::COLOR_W-1:0]            req_line_color,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [COORD_INT_BITS-1:0]        rsp_pixel_x,
   output logic signed [COORD_INT_BITS-1:0]        rsp_pixel_y,
   output logic [aalr_pkg::COLOR_W-1:0]            rsp_pixel_color,
   output logic                                    rsp_last_pixel
);

   localparam int CIB  = COORD_INT_BITS;
   localparam int CFB  = COORD_FRAC_BITS;
   localparam int SFB  = SLOPE_FRAC_BITS;
   localparam int CW   = CIB + CFB;
   localparam int DLW  = CW + 1;
   localparam int NW   = DLW + SFB;
   localparam int RW   = DLW + 1;
   localparam int GW   = SFB + 2;
   localparam int TW   = CW + 2;
   localparam int CLW  = CIB + 1;
   localparam int COLW = CIB + 2;
   localparam int DW   = CFB + 2;
   localparam int PW   = GW + DW;
   localparam int YW   = CIB + SFB + 2;
   localparam int GAPW = CFB + 2;
   localparam int CVW  = aalr_pkg::COV_W;
   localparam int WPW  = CVW + GAPW;
   localparam int SCW  = 8 + CVW;

   localparam logic signed [TW-1:0]   T_HALF  = TW'(2 ** CFB);
   localparam logic [GAPW-1:0]        GAP_ONE = GAPW'(2 ** (CFB + 1));
   localparam logic signed [GW-1:0]   G_ONE   = GW'(2 ** SFB);
   localparam logic signed [COLW-1:0] COL_ONE = COLW'(1);
   localparam logic [SCW-1:0]         SC_RND  = SCW'(128);

   // latched request
   logic signed [CW-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [aalr_pkg::COLOR_W-1:0] held_color_ff, held_color_in;
   // ordered major/minor endpoints
   logic signed [CW-1:0] maj1_ff, min1_ff, maj2_ff, min2_ff;
   logic signed [CW-1:0] maj1_in, min1_in, maj2_in, min2_in;
   logic steep_ff, steep_in, neg_ff, neg_in, zero_ff, zero_in;
   // divider
   logic [DLW-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [NW-1:0]  quo_ff, quo_in;
   // line state
   logic signed [CLW-1:0]  c1_ff, c1_in, c2_ff, c2_in;
   logic [GAPW-1:0]        gap1_ff, gap1_in, gap2_ff, gap2_in;
   logic signed [YW-1:0]   ye1_ff, ye1_in, ye2_ff, ye2_in, yint_ff, yint_in;
   logic signed [GW-1:0]   slope_ff, slope_in;
   logic signed [COLW-1:0] cur_ff, cur_in, fin_ff, fin_in;
   logic                   line_active_ff, line_active_in;
   // prepared pixel
   logic [CIB-1:0] pcol_ff, pcol_in, prow_ff, prow_in;
   logic [CVW-1:0] pcov_ff, pcov_in;
   logic           plast_ff, plast_in;
   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CIB-1:0]               rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [aalr_pkg::COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic                         rsp_last_ff, rsp_last_in;

   // setup terms
   logic signed [DLW-1:0] dx, dy, dmaj, dmin;
   logic [DLW-1:0]        ax, ay, amaj, amin;
   logic signed [CW-1:0]  sa1, sb1, sa2, sb2;
   logic                  steep, swap;
   // divider terms
   logic [RW-1:0]         rem_sh;
   logic                  ge;
   // endpoint terms
   logic signed [GW-1:0]  gmag, g;
   logic signed [CW-1:0]  ep_x [2];
   logic signed [CW-1:0]  ep_y [2];
   logic signed [TW-1:0]  t    [2];
   logic signed [CLW-1:0] c    [2];
   logic [CFB:0]          fr   [2];
   logic signed [DLW-1:0] dfull[2];
   logic signed [DW-1:0]  diff [2];
   logic signed [PW-1:0]  prod [2];
   logic signed [PW-1:0]  sh   [2];
   logic signed [YW-1:0]  ye   [2];
   // pixel terms
   logic signed [COLW-1:0] p_col, p_row, rbase;
   logic signed [YW-1:0]   p_minor;
   logic                   p_upper, p_weight, p_last, adv_last;
   logic [GAPW-1:0]        p_gap;
   logic [7:0]             f8;
   logic [CVW-1:0]         base_cov;
   logic [WPW-1:0]         wprod;
   logic [SCW-1:0]         sc   [3];

   assign status.action      = req_action;
   assign status.line_active = line_active_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

   assign adv_last = (cur_ff >= fin_ff);

   always_comb begin
      dx    = DLW'(x2_ff) - DLW'(x1_ff);
      dy    = DLW'(y2_ff) - DLW'(y1_ff);
      ax    = dx[DLW-1] ? DLW'(-dx) : DLW'(dx);
      ay    = dy[DLW-1] ? DLW'(-dy) : DLW'(dy);
      steep = (ay > ax);
      sa1   = steep ? y1_ff : x1_ff;
      sb1   = steep ? x1_ff : y1_ff;
      sa2   = steep ? y2_ff : x2_ff;
      sb2   = steep ? x2_ff : y2_ff;
      swap  = (sa2 < sa1);
      dmaj  = steep ? dy : dx;
      dmin  = steep ? dx : dy;
      amaj  = steep ? ay : ax;
      amin  = steep ? ax : ay;

      rem_sh = {rem_ff, quo_ff[NW-1]};
      ge     = (rem_sh >= {1'b0, den_ff});

      gmag = GW'({1'b0, quo_ff[SFB:0]});
      if (zero_ff) begin
         g = G_ONE;
      end else if (neg_ff) begin
         g = -gmag;
      end else begin
         g = gmag;
      end

      ep_x[0] = maj1_ff;
      ep_y[0] = min1_ff;
      ep_x[1] = maj2_ff;
      ep_y[1] = min2_ff;
      for (int i = 0; i < 2; i++) begin
         t[i]     = {ep_x[i][CW-1], ep_x[i], 1'b0} + T_HALF;
         c[i]     = t[i][TW-1:CFB+1];
         fr[i]    = t[i][CFB:0];
         dfull[i] = (DLW'(c[i]) <<< CFB) - DLW'(ep_x[i]);
         diff[i]  = dfull[i][DW-1:0];
         prod[i]  = g * diff[i];
         sh[i]    = prod[i] >>> CFB;
         ye[i]    = (YW'(ep_y[i]) <<< (SFB - CFB)) + YW'(sh[i]);
      end

      p_col    = COLW'(cur_ff);
      p_minor  = yint_ff;
      p_upper  = 1'b0;
      p_weight = 1'b0;
      p_gap    = gap1_ff;
      p_last   = 1'b0;
      case (cmd.sel)
         aalr_pkg::PIX_BEGIN_LO: begin
            p_col    = COLW'(c1_ff);
            p_minor  = ye1_ff;
            p_weight = 1'b1;
         end
         aalr_pkg::PIX_BEGIN_HI: begin
            p_col    = COLW'(c1_ff);
            p_minor  = ye1_ff;
            p_upper  = 1'b1;
            p_weight = 1'b1;
         end
         aalr_pkg::PIX_END_LO: begin
            p_col    = COLW'(c2_ff);
            p_minor  = ye2_ff;
            p_weight = 1'b1;
            p_gap    = gap2_ff;
         end
         aalr_pkg::PIX_END_HI: begin
            p_col    = COLW'(c2_ff);
            p_minor  = ye2_ff;
            p_upper  = 1'b1;
            p_weight = 1'b1;
            p_gap    = gap2_ff;
            p_last   = !line_active_ff;
         end
         aalr_pkg::PIX_ADV_LO: begin
            p_col = cur_ff;
         end
         aalr_pkg::PIX_ADV_HI: begin
            p_upper = 1'b1;
            p_last  = adv_last;
         end
         default: begin
            p_col = cur_ff;
         end
      endcase
      f8       = p_minor[SFB-1 -: 8];
      rbase    = p_minor[YW-1:SFB];
      p_row    = rbase + COLW'(p_upper);
      base_cov = p_upper ? {1'b0, f8} : aalr_pkg::COV_FULL - {1'b0, f8};
      wprod    = WPW'(base_cov) * WPW'(p_gap);

      for (int k = 0; k < 3; k++) begin
         sc[k] = SCW'(held_color_ff[8*k +: 8]) * SCW'(pcov_ff) + SC_RND;
      end
   end

   always_comb begin
      held_color_in  = held_color_ff;
      maj1_in        = maj1_ff;
      min1_in        = min1_ff;
      maj2_in        = maj2_ff;
      min2_in        = min2_ff;
      steep_in       = steep_ff;
      neg_in         = neg_ff;
      zero_in        = zero_ff;
      den_in         = den_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      c1_in          = c1_ff;
      c2_in          = c2_ff;
      gap1_in        = gap1_ff;
      gap2_in        = gap2_ff;
      ye1_in         = ye1_ff;
      ye2_in         = ye2_ff;
      slope_in       = slope_ff;
      yint_in        = yint_ff;
      cur_in         = cur_ff;
      fin_in         = fin_ff;
      line_active_in = line_active_ff;
      pcol_in        = pcol_ff;
      prow_in        = prow_ff;
      pcov_in        = pcov_ff;
      plast_in       = plast_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_color_in   = rsp_color_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (cmd.latch && req_action == aalr_pkg::ACT_BEGIN) begin
         held_color_in = req_line_color;
      end
      if (cmd.setup) begin
         steep_in = steep;
         maj1_in  = swap ? sa2 : sa1;
         min1_in  = swap ? sb2 : sb1;
         maj2_in  = swap ? sa1 : sa2;
         min2_in  = swap ? sb1 : sb2;
         neg_in   = dmaj[DLW-1] ^ dmin[DLW-1];
         zero_in  = (amaj == '0);
         den_in   = amaj;
         quo_in   = {amin, SFB'(0)};
         rem_in   = '0;
      end
      if (cmd.div_step) begin
         rem_in = ge ? DLW'(rem_sh - {1'b0, den_ff}) : rem_sh[DLW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
      end
      if (cmd.endp) begin
         c1_in          = c[0];
         c2_in          = c[1];
         gap1_in        = GAP_ONE - GAPW'(fr[0]);
         gap2_in        = GAPW'(fr[1]);
         ye1_in         = ye[0];
         ye2_in         = ye[1];
         slope_in       = g;
         yint_in        = ye[0] + YW'(g);
         cur_in         = COLW'(c[0]) + COL_ONE;
         fin_in         = COLW'(c[1]) - COL_ONE;
         line_active_in = (COLW'(c[0]) + COL_ONE) <= (COLW'(c[1]) - COL_ONE);
      end
      if (cmd.prep) begin
         pcol_in  = p_col[CIB-1:0];
         prow_in  = p_row[CIB-1:0];
         pcov_in  = p_weight ? wprod[CFB+1 +: CVW] : base_cov;
         plast_in = p_last;
      end
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = steep_ff ? prow_ff : pcol_ff;
         rsp_y_in     = steep_ff ? pcol_ff : prow_ff;
         rsp_color_in = {sc[2][15:8], sc[1][15:8], sc[0][15:8]};
         rsp_last_in  = plast_ff;
      end
      if (cmd.advance) begin
         yint_in = yint_ff + YW'(slope_ff);
         if (adv_last) begin
            line_active_in = 1'b0;
         end else begin
            cur_in = cur_ff + COL_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         x1_ff <= req_x_start;
         y1_ff <= req_y_start;
         x2_ff <= req_x_finish;
         y2_ff <= req_y_finish;
      end
      held_color_ff <= held_color_in;
      maj1_ff       <= maj1_in;
      min1_ff       <= min1_in;
      maj2_ff       <= maj2_in;
      min2_ff       <= min2_in;
      steep_ff      <= steep_in;
      neg_ff        <= neg_in;
      zero_ff       <= zero_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      c1_ff         <= c1_in;
      c2_ff         <= c2_in;
      gap1_ff       <= gap1_in;
      gap2_ff       <= gap2_in;
      ye1_ff        <= ye1_in;
      ye2_ff        <= ye2_in;
      slope_ff      <= slope_in;
      yint_ff       <= yint_in;
      cur_ff        <= cur_in;
      fin_ff        <= fin_in;
      pcol_ff       <= pcol_in;
      prow_ff       <= prow_in;
      pcov_ff       <= pcov_in;
      plast_ff      <= plast_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// ===== rtl/core/antialiased_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// Antialiased line rasterizer core
// Wu line rasterizer: begin transfers set up a line, advance transfers step it.
// ----------------------------------------------------------------------------
// A begin transfer is accepted and set up, then the gradient divider develops one
// quotient bit per cycle, COORD_INT_BITS + COORD_FRAC_BITS + 1 + SLOPE_FRAC_BITS
// bits in all (33 by default); then come the endpoint step and a prepare and a
// load for each of the four endpoint pixels, all before the next transfer is taken.
// An advance transfer is accepted, then prepares and loads each of its two
// pixels; an advance with no line active is accepted and gives no pixel. A stall
// on the result side holds the sequence in its load state until the slot is free.
module antialiased_line_rasterizer_core #(
   parameter int COORD_INT_BITS  = 12,
   parameter int COORD_FRAC_BITS = 4,
   parameter int SLOPE_FRAC_BITS = 16
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_valid,
   output logic                                             req_ready,
   input  logic                                             req_action,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_x_start,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_y_start,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_x_finish,
   input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] req_y_finish,
   input  logic [aalr_pkg::COLOR_W-1:0]                     req_line_color,
   output logic                                             rsp_valid,
   input  logic                                             rsp_ready,
   output logic signed [COORD_INT_BITS-1:0]                 rsp_pixel_x,
   output logic signed [COORD_INT_BITS-1:0]                 rsp_pixel_y,
   output logic [aalr_pkg::COLOR_W-1:0]                     rsp_pixel_color,
   output logic                                             rsp_last_pixel
);

   localparam int DIV_STEPS = COORD_INT_BITS + COORD_FRAC_BITS + 1 + SLOPE_FRAC_BITS;

   aalr_pkg::cmd_type    cmd;
   aalr_pkg::status_type status;

   aalr_control #(
      .DIV_STEPS(DIV_STEPS)
   ) u_control (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   aalr_datapath #(
      .COORD_INT_BITS (COORD_INT_BITS),
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_finish   (req_x_finish),
      .req_y_finish   (req_y_finish),
      .req_line_color (req_line_color),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel (rsp_last_pixel)
   );

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid || rsp_ready))
      else $error("pixel loaded over an untaken result");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.load || cmd.div_step || cmd.prep || cmd.endp))
      else $error("request taken while work in flight");

   a_advance_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> (cmd.load && status.line_active))
      else $error("column advanced without an active line");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid)
      else $error("loaded pixel not presented");

endmodule

// ===== tb/aalr_scoreboard.sv =====
// ----------------------------------------------------------------------------
// Antialiased line rasterizer scoreboard
// Watches the request and pixel channels, predicts each pixel from the accepted
// line commands and compares every pixel transfer, all fields at once, in order.
// ----------------------------------------------------------------------------
module aalr_scoreboard (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_action,
   input  logic signed [15:0]  req_x_start,
   input  logic signed [15:0]  req_y_start,
   input  logic signed [15:0]  req_x_finish,
   input  logic signed [15:0]  req_y_finish,
   input  logic [23:0]         req_line_color,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic signed [11:0]  rsp_pixel_x,
   input  logic signed [11:0]  rsp_pixel_y,
   input  logic [23:0]         rsp_pixel_color,
   input  logic                rsp_last_pixel,
   output int                  errors,
   output int                  pending
);

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic [23:0] color;
      logic        last;
   } pixel_type;

   pixel_type pixel_q[$];

   logic        line_on;
   logic        steep;
   longint      column;
   longint      last_column;
   longint      minor_acc;
   longint      gradient;
   logic [23:0] color_hold;

   assign pending = pixel_q.size();

   function automatic logic [23:0] shade(logic [23:0] c, longint b);
      longint r, g, bl;
      r  = (longint'(c[23:16]) * b + 128) >>> 8;
      g  = (longint'(c[15:8]) * b + 128) >>> 8;
      bl = (longint'(c[7:0]) * b + 128) >>> 8;
      return {r[7:0], g[7:0], bl[7:0]};
   endfunction

   task automatic plot(longint col, longint row, longint b, logic last);
      pixel_type p;
      longint px, py;
      px = steep ? row : col;
      py = steep ? col : row;
      p.x = px[11:0];
      p.y = py[11:0];
      p.color = shade(color_hold, b);
      p.last = last;
      pixel_q.push_back(p);
   endtask

   task automatic round_end(longint x, longint y, longint g, output longint col,
                            output longint frac, output longint yend);
      longint t;
      t = 2 * x + 16;
      col = t >>> 5;
      frac = t - col * 32;
      yend = y * 4096 + ((g * (col * 16 - x)) >>> 4);
   endtask

   task automatic predict_line(logic act, longint x1, longint y1, longint x2, longint y2,
                               logic [23:0] c);
      longint dx, dy, tmp, c1, c2, fr1, fr2, ye1, ye2, f1, f2, gap1, gap2;
      if (act == aalr_pkg::ACT_ADVANCE) begin
         if (!line_on) return;
         f1 = (minor_acc & 64'hFFFF) >>> 8;
         f2 = minor_acc >>> 16;
         plot(column, f2, 256 - f1, 1'b0);
         plot(column, f2 + 1, f1, column >= last_column);
         minor_acc += gradient;
         if (column >= last_column) line_on = 1'b0;
         else column += 1;
         return;
      end
      color_hold = c;
      dx = x2 - x1;
      dy = y2 - y1;
      steep = (dy < 0 ? -dy : dy) > (dx < 0 ? -dx : dx);
      if (steep) begin
         tmp = x1; x1 = y1; y1 = tmp;
         tmp = x2; x2 = y2; y2 = tmp;
         tmp = dx; dx = dy; dy = tmp;
      end
      if (x2 < x1) begin
         tmp = x1; x1 = x2; x2 = tmp;
         tmp = y1; y1 = y2; y2 = tmp;
      end
      gradient = (dx != 0) ? (dy * 65536) / dx : 65536;
      round_end(x1, y1, gradient, c1, fr1, ye1);
      round_end(x2, y2, gradient, c2, fr2, ye2);
      gap1 = 32 - fr1;
      gap2 = fr2;
      f1 = (ye1 & 64'hFFFF) >>> 8;
      f2 = (ye2 & 64'hFFFF) >>> 8;
      minor_acc = ye1 + gradient;
      column = c1 + 1;
      last_column = c2 - 1;
      line_on = column <= last_column;
      plot(c1, ye1 >>> 16, ((256 - f1) * gap1) >>> 5, 1'b0);
      plot(c1, (ye1 >>> 16) + 1, (f1 * gap1) >>> 5, 1'b0);
      plot(c2, ye2 >>> 16, ((256 - f2) * gap2) >>> 5, 1'b0);
      plot(c2, (ye2 >>> 16) + 1, (f2 * gap2) >>> 5, !line_on);
   endtask

   always @(posedge clock) begin
      pixel_type exp_p;
      if (reset) begin
         line_on <= 1'b0;
         steep <= 1'b0;
         column <= 0;
         last_column <= 0;
         minor_acc <= 0;
         gradient <= 0;
         color_hold <= '0;
         errors <= 0;
      end else begin
         if (req_valid && req_ready)
            predict_line(req_action, req_x_start, req_y_start, req_x_finish,
                         req_y_finish, req_line_color);
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
                        rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel);
               errors <= errors + 1;
            end else begin
               exp_p = pixel_q.pop_front();
               if (exp_p != {rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel}) begin
                  $display("%0t: pixel mismatch expected x=%0d y=%0d color=%h last=%b",
                           $time, $signed(exp_p.x), $signed(exp_p.y), exp_p.color,
                           exp_p.last);
                  $display("%0t:                actual   x=%0d y=%0d color=%h last=%b",
                           $time, rsp_pixel_x, rsp_pixel_y, rsp_pixel_color,
                           rsp_last_pixel);
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/tb_antialiased_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// Antialiased line rasterizer testbench
// Drives directed and random line commands with random idling on both
// channels; a scoreboard checks every pixel against its own prediction.
// ----------------------------------------------------------------------------
module tb_antialiased_line_rasterizer_core;

   localparam int WATCHDOG_LIMIT = 3000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_action;
   logic signed [15:0] req_x_start;
   logic signed [15:0] req_y_start;
   logic signed [15:0] req_x_finish;
   logic signed [15:0] req_y_finish;
   logic [23:0]        req_line_color;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [11:0] rsp_pixel_x;
   logic signed [11:0] rsp_pixel_y;
   logic [23:0]        rsp_pixel_color;
   logic               rsp_last_pixel;
   int                 errors;
   int                 pending;
   logic               calm;
   int                 quiet_cycles;

   antialiased_line_rasterizer_core i_dut (.*);

   aalr_scoreboard i_scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ready <= calm || ($urandom_range(99) >= 16);
      end
   end

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic transfer(logic act, logic [15:0] xs, logic [15:0] ys, logic [15:0] xf,
                           logic [15:0] yf, logic [23:0] c);
      req_valid <= 1'b1;
      req_action <= act;
      req_x_start <= xs;
      req_y_start <= ys;
      req_x_finish <= xf;
      req_y_finish <= yf;
      req_line_color <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic advance();
      transfer(aalr_pkg::ACT_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 24'($urandom));
   endtask

   task automatic short_line();
      logic [15:0] bx, by;
      int steps;
      bx = 16'($urandom);
      by = 16'($urandom);
      transfer(aalr_pkg::ACT_BEGIN, 16'(bx + $urandom_range(0, 400) - 200),
               16'(by + $urandom_range(0, 400) - 200),
               16'(bx + $urandom_range(0, 400) - 200),
               16'(by + $urandom_range(0, 400) - 200), 24'($urandom));
      steps = ($urandom_range(9) == 0) ? $urandom_range(0, 4) : $urandom_range(0, 28);
      repeat (steps) advance();
   endtask

   initial begin
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = aalr_pkg::ACT_BEGIN;
      req_x_start = '0;
      req_y_start = '0;
      req_x_finish = '0;
      req_y_finish = '0;
      req_line_color = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      advance();
      transfer(aalr_pkg::ACT_BEGIN, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 24'hFFFFFF);
      repeat (3) advance();
      transfer(aalr_pkg::ACT_BEGIN, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 24'h000000);
      advance();
      transfer(aalr_pkg::ACT_BEGIN, 16'sd37, 16'sd53, 16'sd37, 16'sd53, 24'hFFFFFF);
      advance();
      transfer(aalr_pkg::ACT_BEGIN, 16'sd8, 16'sd8, 16'sd24, 16'sd20, 24'h80FF01);
      advance();
      transfer(aalr_pkg::ACT_BEGIN, 16'sd100, 16'sd10, 16'sd140, 16'sd300, 24'h123456);
      repeat (3) advance();
      transfer(aalr_pkg::ACT_BEGIN, -16'sd200, 16'sd71, 16'sd150, -16'sd33, 24'hFF00FF);
      repeat (25) advance();
      transfer(aalr_pkg::ACT_BEGIN, 16'sd5, -16'sd9, -16'sd77, -16'sd120, 24'h00FF00);
      repeat (2) advance();

      for (int n = 0; n < 23; n++) begin
         calm = (n >= 9 && n < 15);
         if ($urandom_range(9) == 0)
            transfer(aalr_pkg::ACT_BEGIN, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 24'($urandom));
         else if ($urandom_range(19) == 0)
            advance();
         else
            short_line();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
